FILE: design/gap_pkg.sv
// Grid A* planner package: request/result structs, action and status codes,
// register indexes and the control structs between top level and search engine.
// No dependencies.
package gap_pkg;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_PLAN = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	localparam logic [2:0] ST_LOADED = 3'd0;
	localparam logic [2:0] ST_FOUND  = 3'd1;
	localparam logic [2:0] ST_NOPATH = 3'd2;
	localparam logic [2:0] ST_CELL   = 3'd3;
	localparam logic [2:0] ST_END    = 3'd4;

	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	typedef struct packed {
		logic [1:0] action;
		logic [5:0] cell_x;
		logic [5:0] cell_y;
		logic       blocked;
		logic [5:0] target_x;
		logic [5:0] target_y;
	} gap_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  path_x;
		logic [5:0]  path_y;
		logic [12:0] path_length;
		logic        last;
	} gap_res_t;

	typedef struct packed {
		logic       load;
		logic       plan;
		logic [5:0] x;
		logic [5:0] y;
		logic       blocked;
		logic [5:0] tx;
		logic [5:0] ty;
	} gap_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic found;
	} gap_sts_t;

endpackage

FILE: design/gap_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/gap_search.sv
// A* search engine: cell memory (occupancy, open/closed, g, f, parent) and
// the sequencer for clear pass, open-set scan, expansion and backtrack.
// Depends on gap_pkg and gap_ram.
module gap_search import gap_pkg::*; #(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_HEIGHT = 64,
	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT,
	localparam int IW = $clog2(CELLS),
	localparam int XB = $clog2(MAX_WIDTH),
	localparam int YB = $clog2(MAX_HEIGHT),
	localparam int PW = XB + YB,
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int HW = $clog2(MAX_HEIGHT + 1),
	localparam int GW = $clog2(CELLS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  gap_cmd_t      cmd,
	input  logic [WW-1:0] grid_w,
	input  logic [HW-1:0] grid_h,
	output gap_sts_t      sts,
	output logic [GW-1:0] plen,
	output logic          pw_en,
	output logic [IW-1:0] pw_addr,
	output logic [PW-1:0] pw_data
);

	localparam int FW = $clog2(CELLS + MAX_WIDTH + MAX_HEIGHT);
	localparam logic [3:0] NB_CENTER = 4'd4;
	localparam logic [3:0] NB_LAST = 4'd8;

	typedef struct packed {
		logic          occ;
		logic          opn;
		logic          cls;
		logic [GW-1:0] g;
		logic [FW-1:0] f;
		logic [PW-1:0] par;
	} cell_t;

	typedef enum logic [10:0] {
		S_INIT     = 11'b00000000001,
		S_IDLE     = 11'b00000000010,
		S_CLR      = 11'b00000000100,
		S_CLR_END  = 11'b00000001000,
		S_SCAN     = 11'b00000010000,
		S_SCAN_END = 11'b00000100000,
		S_CLOSE    = 11'b00001000000,
		S_NB_RD    = 11'b00010000000,
		S_NB_WR    = 11'b00100000000,
		S_BT_W     = 11'b01000000000,
		S_BT_R     = 11'b10000000000
	} state_t;

	function automatic logic [IW-1:0] cell_idx(input logic [YB-1:0] y, input logic [XB-1:0] x);
		return IW'(32'(y) * MAX_WIDTH + 32'(x));
	endfunction

	state_t        state_q;
	logic [IW-1:0] clr_q;
	logic          clr_v_s1;
	logic [IW-1:0] clr_addr_s1;
	logic [XB-1:0] scx_q, scan_x_s1, bx_q, tx_q, st_x_q, nx_q, cur_x_q;
	logic [YB-1:0] scy_q, scan_y_s1, by_q, ty_q, st_y_q, ny_q, cur_y_q;
	logic          scan_v_s1;
	logic          found_q;
	cell_t         bw_q;
	logic [3:0]    nb_q;
	logic          nb_ok_q;
	logic [GW-1:0] k_q, km1, plen_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	cell_t         ram_wdata, ram_rdata;
	cell_t         clr_word, load_word, close_word, new_word;
	logic          take_best, upd, is_target;
	logic signed [XB+1:0] dxs, nxs;
	logic signed [YB+1:0] dys, nys;
	logic          nb_in;
	logic [GW-1:0] ng;
	logic [XB-1:0] hx;
	logic [YB-1:0] hy;

	gap_ram #(.WIDTH($bits(cell_t)), .DEPTH(CELLS)) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// offsets: all ones is -1
	always_comb begin
		case (nb_q)
			4'd0: begin dxs = '1; dys = '1; end
			4'd1: begin dxs = '1; dys = '0; end
			4'd2: begin dxs = '1; dys = (YB+2)'(1); end
			4'd3: begin dxs = '0; dys = '1; end
			4'd5: begin dxs = '0; dys = (YB+2)'(1); end
			4'd6: begin dxs = (XB+2)'(1); dys = '1; end
			4'd7: begin dxs = (XB+2)'(1); dys = '0; end
			4'd8: begin dxs = (XB+2)'(1); dys = (YB+2)'(1); end
			default: begin dxs = '0; dys = '0; end
		endcase
		nxs = $signed({2'b00, bx_q}) + dxs;
		nys = $signed({2'b00, by_q}) + dys;
		nb_in = !nxs[XB+1] && (nxs[XB:0] < (XB+1)'(grid_w)) &&
			!nys[YB+1] && (nys[YB:0] < (YB+1)'(grid_h)) && (nb_q != NB_CENTER);
	end

	always_comb begin
		hx = (nx_q >= tx_q) ? nx_q - tx_q : tx_q - nx_q;
		hy = (ny_q >= ty_q) ? ny_q - ty_q : ty_q - ny_q;
		ng = bw_q.g + GW'(1);
		new_word.occ = ram_rdata.occ;
		new_word.opn = 1'b1;
		new_word.cls = 1'b0;
		new_word.g = ng;
		new_word.f = FW'(ng) + FW'(hx) + FW'(hy);
		new_word.par = {by_q, bx_q};
		upd = nb_ok_q && !ram_rdata.cls && !ram_rdata.occ &&
			(!ram_rdata.opn || (new_word.f < ram_rdata.f));

		clr_word = ram_rdata;
		clr_word.opn = 1'b0;
		clr_word.cls = 1'b0;
		if (clr_addr_s1 == cell_idx(st_y_q, st_x_q)) begin
			clr_word.opn = 1'b1;
			clr_word.g = '0;
			clr_word.f = '0;
			clr_word.par = {st_y_q, st_x_q};
		end

		load_word = '0;
		load_word.occ = cmd.blocked;

		close_word = bw_q;
		close_word.opn = 1'b0;
		close_word.cls = 1'b1;

		take_best = scan_v_s1 && ram_rdata.opn && (!found_q || (ram_rdata.f < bw_q.f));
		is_target = (bx_q == tx_q) && (by_q == ty_q);
		km1 = k_q - GW'(1);
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		ram_raddr = clr_q;
		pw_en = 1'b0;
		pw_addr = km1[IW-1:0];
		pw_data = {cur_y_q, cur_x_q};
		case (state_q)
			S_INIT: begin
				ram_we = 1'b1;
			end
			S_IDLE: begin
				if (cmd.load) begin
					ram_we = 1'b1;
					ram_waddr = cell_idx(YB'(cmd.y), XB'(cmd.x));
					ram_wdata = load_word;
				end
			end
			S_SCAN: ram_raddr = cell_idx(scy_q, scx_q);
			S_CLOSE: begin
				if (found_q) begin
					ram_we = 1'b1;
					ram_waddr = cell_idx(by_q, bx_q);
					ram_wdata = close_word;
				end
			end
			S_NB_RD: ram_raddr = cell_idx(nys[YB-1:0], nxs[XB-1:0]);
			S_NB_WR: begin
				if (upd) begin
					ram_we = 1'b1;
					ram_waddr = cell_idx(ny_q, nx_q);
					ram_wdata = new_word;
				end
			end
			S_BT_W: begin
				pw_en = 1'b1;
				ram_raddr = cell_idx(cur_y_q, cur_x_q);
			end
			default: ;
		endcase
		if (clr_v_s1) begin
			ram_we = 1'b1;
			ram_waddr = clr_addr_s1;
			ram_wdata = clr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			clr_q <= '0;
			clr_v_s1 <= 1'b0;
			scan_v_s1 <= 1'b0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				S_INIT: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(CELLS - 1)) begin
						clr_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd.plan) begin
						st_x_q <= XB'(cmd.x);
						st_y_q <= YB'(cmd.y);
						tx_q <= XB'(cmd.tx);
						ty_q <= YB'(cmd.ty);
						clr_q <= '0;
						state_q <= S_CLR;
					end
				end
				S_CLR: begin
					clr_v_s1 <= 1'b1;
					clr_addr_s1 <= clr_q;
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(CELLS - 1)) begin
						clr_q <= '0;
						state_q <= S_CLR_END;
					end
				end
				S_CLR_END: begin
					clr_v_s1 <= 1'b0;
					scx_q <= '0;
					scy_q <= '0;
					found_q <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					scan_v_s1 <= 1'b1;
					scan_x_s1 <= scx_q;
					scan_y_s1 <= scy_q;
					if (32'(scx_q) == 32'(grid_w) - 1) begin
						scx_q <= '0;
						if (32'(scy_q) == 32'(grid_h) - 1) begin
							state_q <= S_SCAN_END;
						end else begin
							scy_q <= scy_q + YB'(1);
						end
					end else begin
						scx_q <= scx_q + XB'(1);
					end
				end
				S_SCAN_END: begin
					scan_v_s1 <= 1'b0;
					state_q <= S_CLOSE;
				end
				S_CLOSE: begin
					if (!found_q) begin
						state_q <= S_IDLE;
					end else if (is_target) begin
						k_q <= bw_q.g + GW'(1);
						plen_q <= bw_q.g + GW'(1);
						cur_x_q <= tx_q;
						cur_y_q <= ty_q;
						state_q <= S_BT_W;
					end else begin
						nb_q <= '0;
						state_q <= S_NB_RD;
					end
				end
				S_NB_RD: begin
					nb_ok_q <= nb_in;
					nx_q <= nxs[XB-1:0];
					ny_q <= nys[YB-1:0];
					state_q <= S_NB_WR;
				end
				S_NB_WR: begin
					if (nb_q == NB_LAST) begin
						scx_q <= '0;
						scy_q <= '0;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end else begin
						nb_q <= nb_q + 4'd1;
						state_q <= S_NB_RD;
					end
				end
				S_BT_W: begin
					state_q <= (k_q == GW'(1)) ? S_IDLE : S_BT_R;
				end
				S_BT_R: begin
					cur_x_q <= ram_rdata.par[XB-1:0];
					cur_y_q <= ram_rdata.par[PW-1:XB];
					k_q <= km1;
					state_q <= S_BT_W;
				end
				default: state_q <= S_IDLE;
			endcase
			if (take_best) begin
				found_q <= 1'b1;
				bw_q <= ram_rdata;
				bx_q <= scan_x_s1;
				by_q <= scan_y_s1;
			end
		end
	end

	assign sts.busy = (state_q != S_IDLE);
	assign sts.done = ((state_q == S_CLOSE) && !found_q) ||
		((state_q == S_BT_W) && (k_q == GW'(1)));
	assign sts.found = (state_q == S_BT_W);
	assign plen = plen_q;

endmodule

FILE: design/grid_astar_path_planner_top.sv
// Grid A* path planner top level. A load is answered in the next cycle; a path read goes
// through the read-pending register to the result register; one request in flight at a
// time; result strobed on done for one cycle; the receiver cannot stall. Plan: a clear pass
// over all cells, then per expansion an open-set scan of the w*h grid, a close and a read
// and write per neighbor slot, then a backtrack step per path cell. Reset: asynchronous,
// active low; a sweep frees all cells, with busy high. Depends on gap_pkg, gap_ram, gap_search.
module grid_astar_path_planner_top import gap_pkg::*; #(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  gap_req_t    request,
	output logic        done,
	output gap_res_t    result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int IW = $clog2(CELLS);
	localparam int XB = $clog2(MAX_WIDTH);
	localparam int YB = $clog2(MAX_HEIGHT);
	localparam int PW = XB + YB;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int GW = $clog2(CELLS + 1);

	logic [6:0]    gw_q, gh_q;
	logic [WW-1:0] grid_w;
	logic [HW-1:0] grid_h;
	logic          map_q;
	logic [GW-1:0] pc_q, rp_q, rp_inc;
	logic          rd_pend_q, last_s1;
	logic          done_q, last_q;
	logic [2:0]    status_q;
	logic [5:0]    px_q, py_q;
	logic          accept, load_ok, plan_ok;
	gap_cmd_t      cmd;
	gap_sts_t      sts;
	logic [GW-1:0] plen;
	logic          pw_en;
	logic [IW-1:0] pw_addr;
	logic [PW-1:0] pw_data, prd;

	always_comb begin
		if (gw_q == 7'd0) grid_w = WW'(1);
		else if (32'(gw_q) > MAX_WIDTH) grid_w = WW'(MAX_WIDTH);
		else grid_w = WW'(gw_q);
		if (gh_q == 7'd0) grid_h = HW'(1);
		else if (32'(gh_q) > MAX_HEIGHT) grid_h = HW'(MAX_HEIGHT);
		else grid_h = HW'(gh_q);
	end

	assign busy = sts.busy || rd_pend_q;
	assign accept = start && !busy;
	assign load_ok = (32'(request.cell_x) < 32'(grid_w)) && (32'(request.cell_y) < 32'(grid_h));
	assign plan_ok = map_q && load_ok &&
		(32'(request.target_x) < 32'(grid_w)) && (32'(request.target_y) < 32'(grid_h));
	assign rp_inc = rp_q + GW'(1);

	always_comb begin
		cmd.load = accept && (request.action == ACT_LOAD) && load_ok;
		cmd.plan = accept && (request.action == ACT_PLAN) && plan_ok;
		cmd.x = request.cell_x;
		cmd.y = request.cell_y;
		cmd.blocked = request.blocked;
		cmd.tx = request.target_x;
		cmd.ty = request.target_y;
	end

	gap_search #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.grid_w (grid_w),
		.grid_h (grid_h),
		.sts    (sts),
		.plen   (plen),
		.pw_en  (pw_en),
		.pw_addr(pw_addr),
		.pw_data(pw_data)
	);

	gap_ram #(.WIDTH(PW), .DEPTH(CELLS)) u_path (
		.clk  (clk),
		.we   (pw_en),
		.waddr(pw_addr),
		.wdata(pw_data),
		.raddr(rp_q[IW-1:0]),
		.rdata(prd)
	);

	// configuration port
	assign pready = 1'b1;
	assign prdata = {25'd0, (paddr[2] == REG_GRID_HEIGHT) ? gh_q : gw_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= 7'd64;
			gh_q <= 7'd64;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_GRID_WIDTH: gw_q <= pwdata[6:0];
				REG_GRID_HEIGHT: gh_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// request handling and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= 1'b0;
			pc_q <= '0;
			rp_q <= '0;
			rd_pend_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (rd_pend_q) begin
				rd_pend_q <= 1'b0;
				done_q <= 1'b1;
				status_q <= ST_CELL;
				px_q <= 6'(prd[XB-1:0]);
				py_q <= 6'(prd[PW-1:XB]);
				last_q <= last_s1;
			end
			if (sts.done) begin
				done_q <= 1'b1;
				status_q <= sts.found ? ST_FOUND : ST_NOPATH;
				if (sts.found) pc_q <= plen;
				px_q <= '0;
				py_q <= '0;
				last_q <= 1'b0;
			end
			if (accept) begin
				px_q <= '0;
				py_q <= '0;
				last_q <= 1'b0;
				case (request.action)
					ACT_LOAD: begin
						map_q <= 1'b1;
						done_q <= 1'b1;
						status_q <= ST_LOADED;
					end
					ACT_PLAN: begin
						pc_q <= '0;
						rp_q <= '0;
						if (!plan_ok) begin
							done_q <= 1'b1;
							status_q <= ST_NOPATH;
						end
					end
					ACT_READ: begin
						if (rp_q < pc_q) begin
							rd_pend_q <= 1'b1;
							last_s1 <= (rp_inc == pc_q);
							rp_q <= rp_inc;
						end else begin
							done_q <= 1'b1;
							status_q <= ST_END;
						end
					end
					default: begin
						done_q <= 1'b1;
						status_q <= ST_END;
					end
				endcase
			end
		end
	end

	assign done = done_q;
	always_comb begin
		result.status = status_q;
		result.path_x = px_q;
		result.path_y = py_q;
		result.path_length = 13'(pc_q);
		result.last = last_q;
	end

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |=> done && (result.status == ST_CELL))
		else $error("path read did not return a path cell");

	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= pc_q)
		else $error("read pointer beyond path count");

	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_FOUND) |-> (pc_q != '0))
		else $error("path found with zero length");

	a_no_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.busy |-> !cmd.load && !cmd.plan)
		else $error("command issued to busy search engine");

endmodule

FILE: tb/tb_top.sv
// Testbench for grid_astar_path_planner_top: directed table then random load/plan/read
// sequences over several grid sizes, checked against an in-bench A* predictor.
// Depends on gap_pkg and the planner RTL.
module tb_top;
	import gap_pkg::*;

	localparam int CELLS = 4096;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	gap_req_t    request = '0;
	logic        done;
	gap_res_t    result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	grid_astar_path_planner_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// planner state mirror
	bit       occ [CELLS];
	bit       map_ok;
	bit       opn [CELLS];
	bit       cls [CELLS];
	int       gcost [CELLS];
	int       fcost [CELLS];
	int       parent [CELLS];
	int       route [CELLS];
	int       route_len;
	int       route_ptr;
	int       grid_w_reg = 64;
	int       grid_h_reg = 64;

	gap_res_t pending_results[$];
	int       errors = 0;
	int       n_items = 0;
	int       n_results = 0;
	int       n_found = 0;
	bit       no_gaps = 1'b0;

	function automatic int eff_dim(int v);
		if (v == 0) return 1;
		return (v > 64) ? 64 : v;
	endfunction

	function automatic int adiff(int a, int b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic bit astar(int sx, int sy, int tx, int ty, int w, int h);
		int s, t, best, bestf, g, cx, cy, nx, ny, n, ng, nf, cur, len;
		bit hit;
		for (int i = 0; i < CELLS; i++) begin
			opn[i] = 0;
			cls[i] = 0;
		end
		s = sy * 64 + sx;
		t = ty * 64 + tx;
		opn[s] = 1;
		gcost[s] = 0;
		fcost[s] = 0;
		parent[s] = s;
		forever begin
			hit = 0;
			best = 0;
			bestf = 0;
			for (int y = 0; y < h; y++)
				for (int x = 0; x < w; x++)
					if (opn[y*64+x] && (!hit || fcost[y*64+x] < bestf)) begin
						hit = 1;
						bestf = fcost[y*64+x];
						best = y * 64 + x;
					end
			if (!hit) return 0;
			g = gcost[best];
			opn[best] = 0;
			cls[best] = 1;
			if (best == t) begin
				len = (g + 1 > CELLS) ? CELLS : g + 1;
				cur = t;
				for (int k = len; k > 0; k--) begin
					route[k-1] = cur;
					cur = parent[cur] % CELLS;
				end
				route_len = len;
				return 1;
			end
			cx = best % 64;
			cy = best / 64;
			for (int dx = -1; dx <= 1; dx++)
				for (int dy = -1; dy <= 1; dy++) begin
					nx = cx + dx;
					ny = cy + dy;
					if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
					n = ny * 64 + nx;
					if (cls[n] || occ[n]) continue;
					ng = g + 1;
					nf = ng + adiff(nx, tx) + adiff(ny, ty);
					if (!opn[n]) opn[n] = 1;
					else if (!(nf < fcost[n])) continue;
					gcost[n] = ng;
					fcost[n] = nf;
					parent[n] = best;
				end
		end
	endfunction

	function automatic gap_res_t planner_step(gap_req_t r);
		gap_res_t o;
		int w, h, c;
		w = eff_dim(grid_w_reg);
		h = eff_dim(grid_h_reg);
		o = '0;
		o.status = ST_END;
		if (r.action == ACT_LOAD) begin
			if (r.cell_x < w && r.cell_y < h) occ[r.cell_y*64 + r.cell_x] = r.blocked;
			map_ok = 1;
			o.status = ST_LOADED;
		end else if (r.action == ACT_PLAN) begin
			route_len = 0;
			route_ptr = 0;
			if (map_ok && r.cell_x < w && r.cell_y < h && r.target_x < w && r.target_y < h
					&& astar(r.cell_x, r.cell_y, r.target_x, r.target_y, w, h))
				o.status = ST_FOUND;
			else
				o.status = ST_NOPATH;
		end else if (r.action == ACT_READ) begin
			if (route_ptr < route_len) begin
				c = route[route_ptr % CELLS];
				o.path_x = 6'(c % 64);
				o.path_y = 6'(c / 64);
				o.last = (route_ptr + 1 == route_len);
				route_ptr++;
				o.status = ST_CELL;
			end
		end
		o.path_length = 13'(route_len);
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("MISMATCH %s: got %0d, expected %0d", what, got, want);
	endtask

	always @(posedge clk) begin
		gap_res_t want;
		if (arst_n && done) begin
			n_results++;
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending", result.status, -1);
			end else begin
				want = pending_results.pop_front();
				if (result.status != want.status)
					report_mismatch("status", result.status, want.status);
				if (result.path_x != want.path_x)
					report_mismatch("path_x", result.path_x, want.path_x);
				if (result.path_y != want.path_y)
					report_mismatch("path_y", result.path_y, want.path_y);
				if (result.path_length != want.path_length)
					report_mismatch("path_length", result.path_length, want.path_length);
				if (result.last != want.last)
					report_mismatch("last", result.last, want.last);
			end
		end
	end

	// send one request; typed_ok selects a hand-written expectation
	task automatic send(gap_req_t r, bit typed_ok = 0, gap_res_t typed = '0);
		gap_res_t p;
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= r;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		p = planner_step(r);
		if (p.status == ST_FOUND) n_found++;
		pending_results.push_back(typed_ok ? typed : p);
		n_items++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic reg_write(logic idx, int val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		forever begin
			@(posedge clk);
			if (pready) break;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_GRID_WIDTH) grid_w_reg = val & 8'h7f;
		else grid_h_reg = val & 8'h7f;
	endtask

	function automatic gap_req_t mk(logic [1:0] a, int x, int y, bit b, int tx, int ty);
		gap_req_t r;
		r.action = a;
		r.cell_x = 6'(x);
		r.cell_y = 6'(y);
		r.blocked = b;
		r.target_x = 6'(tx);
		r.target_y = 6'(ty);
		return r;
	endfunction

	function automatic gap_res_t rs(logic [2:0] s, int x, int y, int len, bit l);
		gap_res_t o;
		o.status = s;
		o.path_x = 6'(x);
		o.path_y = 6'(y);
		o.path_length = 13'(len);
		o.last = l;
		return o;
	endfunction

	typedef struct {
		gap_req_t rq;
		bit       typed_ok;
		gap_res_t typed;
	} row_t;

	task automatic random_phase(int wv, int hv, int count);
		int w, h, big, n, sx, sy, tx, ty, ex, ey;
		gap_req_t r;
		reg_write(REG_GRID_WIDTH, wv);
		reg_write(REG_GRID_HEIGHT, hv);
		w = eff_dim(wv);
		h = eff_dim(hv);
		big = (w * h > 512);
		no_gaps = ($urandom_range(0, 3) == 0);
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 7) == 0) begin
				r = $bits(gap_req_t)'($urandom);
				if (r.action == ACT_PLAN) r.action = 2'd3;
				if (big && r.action == ACT_LOAD) r.blocked = 0;
				send(r);
				n++;
				continue;
			end
			repeat ($urandom_range(0, 4)) begin
				r = mk(ACT_LOAD, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
					big ? 0 : ($urandom_range(0, 2) == 0), $urandom, $urandom);
				if ($urandom_range(0, 7) == 0) begin
					r.cell_x = 6'($urandom);
					r.cell_y = 6'($urandom);
				end
				send(r);
				n++;
			end
			sx = $urandom_range(0, w - 1);
			sy = $urandom_range(0, h - 1);
			if (big) begin
				tx = sx + $urandom_range(0, 2) - 1;
				ty = sy + $urandom_range(0, 2) - 1;
				if (tx < 0 || ty < 0 || tx >= w || ty >= h || occ[ty*64+tx]) begin
					tx = sx;
					ty = sy;
				end
			end else begin
				tx = $urandom_range(0, w - 1);
				ty = $urandom_range(0, h - 1);
				if ($urandom_range(0, 9) == 0) begin
					sx = $urandom_range(0, 63);
					ty = $urandom_range(0, 63);
				end
			end
			send(mk(ACT_PLAN, sx, sy, $urandom, tx, ty));
			n++;
			ex = route_len + $urandom_range(0, 2);
			if ($urandom_range(0, 4) == 0) ex = $urandom_range(0, route_len);
			if (ex > count - n) ex = (count > n) ? count - n : 0;
			repeat (ex) begin
				send(mk(ACT_READ, $urandom, $urandom, $urandom, $urandom, $urandom));
				n++;
			end
		end
		drain();
	endtask

	initial begin
		row_t table_rows[$];
		for (int i = 0; i < CELLS; i++) occ[i] = 0;
		map_ok = 0;
		route_len = 0;
		route_ptr = 0;
		table_rows = '{
			'{mk(ACT_READ, 0, 0, 0, 0, 0), 1, rs(ST_END, 0, 0, 0, 0)},
			'{mk(ACT_PLAN, 3, 3, 0, 3, 3), 1, rs(ST_NOPATH, 0, 0, 0, 0)},
			'{mk(2'd3, 63, 63, 1, 63, 63), 1, rs(ST_END, 0, 0, 0, 0)},
			'{mk(ACT_LOAD, 0, 0, 1, 0, 0), 1, rs(ST_LOADED, 0, 0, 0, 0)},
			'{mk(ACT_LOAD, 63, 63, 0, 63, 63), 1, rs(ST_LOADED, 0, 0, 0, 0)},
			'{mk(ACT_PLAN, 5, 5, 0, 5, 5), 1, rs(ST_FOUND, 0, 0, 1, 0)},
			'{mk(ACT_READ, 0, 0, 0, 0, 0), 1, rs(ST_CELL, 5, 5, 1, 1)},
			'{mk(ACT_READ, 0, 0, 0, 0, 0), 1, rs(ST_END, 0, 0, 1, 0)},
			'{mk(ACT_PLAN, 0, 0, 0, 1, 1), 0, rs(ST_END, 0, 0, 0, 0)},
			'{mk(ACT_READ, 0, 0, 0, 0, 0), 0, rs(ST_END, 0, 0, 0, 0)},
			'{mk(ACT_READ, 0, 0, 0, 0, 0), 0, rs(ST_END, 0, 0, 0, 0)},
			'{mk(ACT_READ, 0, 0, 0, 0, 0), 0, rs(ST_END, 0, 0, 0, 0)},
			'{mk(ACT_PLAN, 62, 63, 1, 63, 62), 0, rs(ST_END, 0, 0, 0, 0)},
			'{mk(ACT_READ, 63, 0, 1, 0, 63), 0, rs(ST_END, 0, 0, 0, 0)},
			'{mk(ACT_READ, 0, 63, 1, 63, 0), 0, rs(ST_END, 0, 0, 0, 0)},
			'{mk(ACT_PLAN, 0, 0, 0, 0, 0), 0, rs(ST_END, 0, 0, 0, 0)},
			'{mk(ACT_READ, 0, 0, 0, 0, 0), 0, rs(ST_END, 0, 0, 0, 0)}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		reg_write(REG_GRID_WIDTH, 64);
		reg_write(REG_GRID_HEIGHT, 64);
		foreach (table_rows[i]) send(table_rows[i].rq, table_rows[i].typed_ok,
			table_rows[i].typed);
		drain();
		random_phase(0, 0, 8);
		random_phase(6, 5, 20);
		random_phase(1, 64, 15);
		random_phase(127, 3, 20);
		random_phase(127, 127, 15);
		random_phase(8, 8, 20);
		random_phase($urandom_range(1, 8), $urandom_range(1, 8), 20);
		random_phase(2, 1, 10);
		$display("Covered %0d requests and %0d results, %0d plans with a path found,",
			n_items, n_results, n_found);
		$display("over grids from 1x1 to 64x64 including out-of-range size registers.");
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#600000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
